FILE: rtl/rsi_pkg.sv
package rsi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	// multiplier digit width: one digit of the second operand per stage
	localparam int MUL_DIGIT_W = 16;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] origin_x;
		logic signed [COORD_WIDTH-1:0] origin_y;
		logic signed [COORD_WIDTH-1:0] origin_z;
		logic signed [COORD_WIDTH-1:0] dir_x;
		logic signed [COORD_WIDTH-1:0] dir_y;
		logic signed [COORD_WIDTH-1:0] dir_z;
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [COORD_WIDTH-1:0] center_z;
		logic        [COORD_WIDTH-2:0] radius;
	} ray_req_t;

	typedef struct packed {
		logic                          hit_ahead;
		logic                          miss;
		logic signed [COORD_WIDTH-1:0] near_t;
	} ray_res_t;

endpackage

FILE: rtl/ray_sphere_intersect.sv
// Ray against sphere, one request per cycle, fully pipelined.
// With W = COORD_WIDTH, the path has ND = (2W+3)/16 + 1 multiplier digit
// stages and SW = 2W+2+FRAC_BITS square-root stages. Throughput: one
// request per cycle, busy is always low. The receiver cannot stall; the result
// shows for one cycle with done. Reset (arst_n low) clears all valid bits; data
// registers are not reset.
module ray_sphere_intersect #(
	parameter int FRAC_BITS = rsi_pkg::FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rsi_pkg::ray_req_t req,
	output logic             done,
	output rsi_pkg::ray_res_t result
);

	localparam int W    = rsi_pkg::COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int XW   = 2*W + 3;
	localparam int PW   = 2*XW;
	localparam int DQW  = PW + 1;
	localparam int HTW  = PW + 2*F + 1;
	localparam int SW   = 2*W + 2 + F;
	localparam int RW   = 2*SW;
	localparam int NW   = 2*W + F + 5;
	localparam int CMPW = 3*W + F + 6;
	localparam int ND   = XW / rsi_pkg::MUL_DIGIT_W + 1;
	localparam int SQSW = 2*W + XW + 3;
	localparam int LAT  = ND + SW + W + 7;

	localparam logic signed [W-1:0] NEG_ONE = {{(W-F){1'b1}}, {F{1'b0}}};
	localparam logic signed [W-1:0] T_HI    = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] T_LO    = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic neg;
		logic sat_hi;
		logic sat_lo;
		logic hit;
		logic miss;
		logic spec;
	} div_ctl_t;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	logic signed [W-1:0] o_in [3];
	logic signed [W-1:0] c_in [3];
	logic signed [W-1:0] d_in [3];

	always_comb begin
		o_in[0] = req.origin_x;
		o_in[1] = req.origin_y;
		o_in[2] = req.origin_z;
		c_in[0] = req.center_x;
		c_in[1] = req.center_y;
		c_in[2] = req.center_z;
		d_in[0] = req.dir_x;
		d_in[1] = req.dir_y;
		d_in[2] = req.dir_z;
	end

	// stage 1: oc = origin - center
	logic                v_s1;
	logic signed [W-1:0] d_s1  [3];
	logic signed [W:0]   oc_s1 [3];
	logic        [W-2:0] r_s1;

	// stage 2: products
	logic                  v_s2;
	logic signed [2*W-1:0] aa_s2 [3];
	logic signed [2*W:0]   bb_s2 [3];
	logic signed [2*W+1:0] cc_s2 [3];
	logic signed [2*W-1:0] rr_s2;

	// stage 3: A, B, C
	logic                 v_s3;
	logic signed [XW-1:0] a_s3;
	logic signed [XW-1:0] b_s3;
	logic signed [XW-1:0] c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i]  <= d_in[i];
			oc_s1[i] <= {o_in[i][W-1], o_in[i]} - {c_in[i][W-1], c_in[i]};
			aa_s2[i] <= d_s1[i] * d_s1[i];
			bb_s2[i] <= d_s1[i] * oc_s1[i];
			cc_s2[i] <= oc_s1[i] * oc_s1[i];
		end
		r_s1  <= req.radius;
		rr_s2 <= $signed({1'b0, r_s1}) * $signed({1'b0, r_s1});
		a_s3  <= XW'(aa_s2[0]) + XW'(aa_s2[1]) + XW'(aa_s2[2]);
		b_s3  <= XW'(bb_s2[0]) + XW'(bb_s2[1]) + XW'(bb_s2[2]);
		c_s3  <= XW'(cc_s2[0]) + XW'(cc_s2[1]) + XW'(cc_s2[2]) - XW'(rr_s2);
	end

	// B*B and A*C side by side, same depth
	logic                 mul0_v;
	logic                 mul1_v;
	logic signed [PW-1:0] b2;
	logic signed [PW-1:0] ac;
	logic [2*XW-1:0]      mul0_side;
	logic [XW-1:0]        mul1_side;

	rsi_mul #(.AW(XW), .BW(XW), .SIDE_W(2*XW)) u_mul_bb (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s3),
		.a        (b_s3),
		.b        (b_s3),
		.side_in  ({b_s3, c_s3}),
		.out_v    (mul0_v),
		.p        (b2),
		.side_out (mul0_side)
	);

	rsi_mul #(.AW(XW), .BW(XW), .SIDE_W(XW)) u_mul_ac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s3),
		.a        (a_s3),
		.b        (c_s3),
		.side_in  (a_s3),
		.out_v    (mul1_v),
		.p        (ac),
		.side_out (mul1_side)
	);

	// stage 4: discriminant, flags, radicand
	logic signed [XW-1:0]  b4;
	logic signed [XW-1:0]  c4;
	logic signed [XW-1:0]  a4;
	logic signed [HTW-1:0] ht;
	logic signed [DQW-1:0] dq;
	logic                  hit4;
	logic                  miss4;
	logic                  spec4;

	always_comb begin
		b4    = $signed(mul0_side[2*XW-1:XW]);
		c4    = $signed(mul0_side[XW-1:0]);
		a4    = $signed(mul1_side);
		// hit test with a taken as one: B^2 - C * 2^(2F) >= 0
		ht    = HTW'(b2) - (HTW'(c4) <<< (2*F));
		hit4  = c4[XW-1] || (b4[XW-1] && !ht[HTW-1]);
		dq    = DQW'(b2) - DQW'(ac);
		miss4 = dq[DQW-1];
		spec4 = miss4 || (a4 == '0);
	end

	logic                 v_s4;
	logic [2*W-1:0]       a_s4;
	logic signed [XW-1:0] b_s4;
	logic                 hit_s4;
	logic                 miss_s4;
	logic                 spec_s4;
	logic [RW-1:0]        rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= mul0_v;
		end
	end

	always_ff @(posedge clk) begin
		a_s4    <= a4[2*W-1:0];
		b_s4    <= b4;
		hit_s4  <= hit4;
		miss_s4 <= miss4;
		spec_s4 <= spec4;
		rad_s4  <= spec4 ? '0 : (RW'($unsigned(dq)) << (2*F));
	end

	logic            sq_v;
	logic [SW-1:0]   sq_root;
	logic [SQSW-1:0] sq_side;

	rsi_isqrt #(.RW(RW), .SIDE_W(SQSW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s4),
		.rad      (rad_s4),
		.side_in  ({a_s4, b_s4, hit_s4, miss_s4, spec_s4}),
		.out_v    (sq_v),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// stage 5: numerator -B*2^F - sqrt
	logic signed [XW-1:0] b5;
	logic                 v_s5;
	logic signed [NW-1:0] num_s5;
	logic [2*W-1:0]       a_s5;
	logic                 hit_s5;
	logic                 miss_s5;
	logic                 spec_s5;

	assign b5 = $signed(sq_side[XW+2:3]);

	// stage 6: saturation checks and magnitude
	logic signed [CMPW-1:0] num_x;
	logic signed [CMPW-1:0] lim_x;
	logic                   v_s6;
	logic [NW-1:0]          m_s6;
	logic [2*W-1:0]         a_s6;
	div_ctl_t               ctl_s6;

	always_comb begin
		num_x = CMPW'(num_s5);
		lim_x = CMPW'(a_s5) << (W-1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s5 <= sq_v;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		num_s5         <= -(NW'(b5) <<< F) - NW'(sq_root);
		a_s5           <= sq_side[SQSW-1 -: 2*W];
		hit_s5         <= sq_side[2];
		miss_s5        <= sq_side[1];
		spec_s5        <= sq_side[0];
		m_s6           <= num_s5[NW-1] ? NW'(-num_s5) : NW'(num_s5);
		a_s6           <= a_s5;
		ctl_s6.neg     <= num_s5[NW-1];
		ctl_s6.sat_hi  <= (num_x >= lim_x);
		ctl_s6.sat_lo  <= (num_x < -lim_x);
		ctl_s6.hit     <= hit_s5;
		ctl_s6.miss    <= miss_s5;
		ctl_s6.spec    <= spec_s5;
	end

	// restoring divide, one quotient bit per stage; |num| < A * 2^W here
	logic           div_v_s   [W];
	logic [2*W-1:0] div_rem_s [W];
	logic [W-1:0]   div_mq_s  [W];
	logic [W-1:0]   div_q_s   [W];
	logic [2*W-1:0] div_a_s   [W];
	div_ctl_t       div_ctl_s [W];

	for (genvar k = 0; k < W; k++) begin : g_div
		logic           v_in;
		logic [2*W-1:0] rem_in;
		logic [W-1:0]   mq_in;
		logic [W-1:0]   q_in;
		logic [2*W-1:0] a_in;
		div_ctl_t       ctl_in;
		logic [2*W:0]   cur;
		logic [2*W:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in   = v_s6;
			assign rem_in = (2*W)'(m_s6 >> W);
			assign mq_in  = m_s6[W-1:0];
			assign q_in   = '0;
			assign a_in   = a_s6;
			assign ctl_in = ctl_s6;
		end else begin : g_next
			assign v_in   = div_v_s[k-1];
			assign rem_in = div_rem_s[k-1];
			assign mq_in  = div_mq_s[k-1];
			assign q_in   = div_q_s[k-1];
			assign a_in   = div_a_s[k-1];
			assign ctl_in = div_ctl_s[k-1];
		end

		always_comb begin
			cur  = {rem_in, mq_in[W-1]};
			diff = cur - {1'b0, a_in};
			ge   = (cur >= {1'b0, a_in});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else begin
				div_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			div_rem_s[k] <= ge ? diff[2*W-1:0] : cur[2*W-1:0];
			div_mq_s[k]  <= mq_in << 1;
			div_q_s[k]   <= {q_in[W-2:0], ge};
			div_a_s[k]   <= a_in;
			div_ctl_s[k] <= ctl_in;
		end
	end

	// output stage: floor correction for negative numerator, then overrides
	div_ctl_t            ctl_o;
	logic [W-1:0]        q_o;
	logic signed [W-1:0] tq;
	logic signed [W-1:0] t_o;

	always_comb begin
		ctl_o = div_ctl_s[W-1];
		q_o   = div_q_s[W-1];
		if (ctl_o.neg) begin
			tq = $signed(~q_o + W'(div_rem_s[W-1] == '0));
		end else begin
			tq = $signed(q_o);
		end
		if (ctl_o.spec) begin
			t_o = NEG_ONE;
		end else if (ctl_o.sat_hi) begin
			t_o = T_HI;
		end else if (ctl_o.sat_lo) begin
			t_o = T_LO;
		end else begin
			t_o = tq;
		end
	end

	logic              done_q;
	rsi_pkg::ray_res_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v_s[W-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.hit_ahead <= ctl_o.hit;
		result_q.miss      <= ctl_o.miss;
		result_q.near_t    <= t_o;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete after fixed latency");

	a_mul_align: assert property (@(posedge clk) disable iff (!arst_n)
		mul0_v == mul1_v)
		else $error("multiplier pipelines out of step");

	a_miss_t: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.miss) |-> (result.near_t == NEG_ONE))
		else $error("miss result without -1.0 distance");
`endif

endmodule

FILE: rtl/rsi_mul.sv
module rsi_mul #(
	parameter int AW     = 67,
	parameter int BW     = 67,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_v,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	input  logic        [SIDE_W-1:0] side_in,
	output logic                     out_v,
	output logic signed [AW+BW-1:0]  p,
	output logic        [SIDE_W-1:0] side_out
);

	localparam int DG  = rsi_pkg::MUL_DIGIT_W;
	localparam int ND  = BW / DG + 1;
	localparam int BPW = ND * DG;
	localparam int PW  = AW + BW;
	localparam int PDW = AW + DG + 1;

	logic                     v_s    [ND];
	logic signed [AW-1:0]     a_s    [ND];
	logic        [BPW-1:0]    b_s    [ND];
	logic signed [PW-1:0]     acc_s  [ND];
	logic        [SIDE_W-1:0] side_s [ND];

	logic [BPW-1:0] b_ext;

	assign b_ext = {{(BPW-BW){b[BW-1]}}, b};

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic                     v_in;
		logic signed [AW-1:0]     a_in;
		logic        [BPW-1:0]    b_in;
		logic signed [PW-1:0]     acc_in;
		logic        [SIDE_W-1:0] side_in_k;
		logic        [DG-1:0]     dig;
		logic signed [DG:0]       dsg;
		logic signed [PDW-1:0]    prod;
		logic signed [PW-1:0]    acc_nx;

		if (k == 0) begin : g_first
			assign v_in      = in_v;
			assign a_in      = a;
			assign b_in      = b_ext;
			assign acc_in    = '0;
			assign side_in_k = side_in;
		end else begin : g_next
			assign v_in      = v_s[k-1];
			assign a_in      = a_s[k-1];
			assign b_in      = b_s[k-1];
			assign acc_in    = acc_s[k-1];
			assign side_in_k = side_s[k-1];
		end

		always_comb begin
			dig = b_in[k*DG +: DG];
			// top digit carries the sign of the operand
			if (k == ND-1) begin
				dsg = $signed({dig[DG-1], dig});
			end else begin
				dsg = $signed({1'b0, dig});
			end
			prod   = a_in * dsg;
			acc_nx = acc_in + ({{(PW-PDW){prod[PDW-1]}}, prod} << (k*DG));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			a_s[k]    <= a_in;
			b_s[k]    <= b_in;
			acc_s[k]  <= acc_nx;
			side_s[k] <= side_in_k;
		end
	end

	assign out_v    = v_s[ND-1];
	assign p        = acc_s[ND-1];
	assign side_out = side_s[ND-1];

endmodule

FILE: rtl/rsi_isqrt.sv
module rsi_isqrt #(
	parameter int RW     = 164,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_v,
	input  logic        [RW-1:0]     rad,
	input  logic        [SIDE_W-1:0] side_in,
	output logic                     out_v,
	output logic        [RW/2-1:0]   root,
	output logic        [SIDE_W-1:0] side_out
);

	localparam int SW  = RW / 2;
	localparam int RMW = SW + 3;

	logic              v_s    [SW];
	logic [RW-1:0]     rad_s  [SW];
	logic [RMW-1:0]    rem_s  [SW];
	logic [SW-1:0]     root_s [SW];
	logic [SIDE_W-1:0] side_s [SW];

	// one root bit per stage, most significant first
	for (genvar k = 0; k < SW; k++) begin : g_stage
		logic              v_in;
		logic [RW-1:0]     rad_in;
		logic [RMW-1:0]    rem_in;
		logic [SW-1:0]     root_in;
		logic [SIDE_W-1:0] side_in_k;
		logic [RMW-1:0]    cur;
		logic [RMW-1:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in      = in_v;
			assign rad_in    = rad;
			assign rem_in    = '0;
			assign root_in   = '0;
			assign side_in_k = side_in;
		end else begin : g_next
			assign v_in      = v_s[k-1];
			assign rad_in    = rad_s[k-1];
			assign rem_in    = rem_s[k-1];
			assign root_in   = root_s[k-1];
			assign side_in_k = side_s[k-1];
		end

		always_comb begin
			cur   = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
			trial = RMW'({root_in, 2'b01});
			ge    = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= rad_in << 2;
			rem_s[k]  <= ge ? (cur - trial) : cur;
			root_s[k] <= {root_in[SW-2:0], ge};
			side_s[k] <= side_in_k;
		end
	end

	assign out_v    = v_s[SW-1];
	assign root     = root_s[SW-1];
	assign side_out = side_s[SW-1];

endmodule

FILE: tb/sv/tb_ray_sphere_intersect.sv
module tb_ray_sphere_intersect;

	typedef logic signed [255:0] wide_t;

	localparam int LATENCY = 126;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	rsi_pkg::ray_req_t req;
	logic              done;
	rsi_pkg::ray_res_t result;

	rsi_pkg::ray_res_t expected_hits[$];
	int                errors;
	int                sent;
	int                checked;
	int                send_idle_pct;

	ray_sphere_intersect dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// exact wide-integer solution of the quadratic
	function automatic rsi_pkg::ray_res_t solve_sphere(rsi_pkg::ray_req_t r);
		wide_t    dx, dy, dz, ox, oy, oz, rad, a, b, c, b2, dq, sq_arg, root, trial;
		wide_t    num, q, rem, hi, lo;
		rsi_pkg::ray_res_t res;
		dx = wide_t'(r.dir_x);
		dy = wide_t'(r.dir_y);
		dz = wide_t'(r.dir_z);
		ox = wide_t'(r.origin_x) - wide_t'(r.center_x);
		oy = wide_t'(r.origin_y) - wide_t'(r.center_y);
		oz = wide_t'(r.origin_z) - wide_t'(r.center_z);
		rad = wide_t'(r.radius);
		a = dx * dx + dy * dy + dz * dz;
		b = dx * ox + dy * oy + dz * oz;
		c = ox * ox + oy * oy + oz * oz - rad * rad;
		b2 = b * b;
		res.hit_ahead = (c < 0) ||
			((b < 0) && ((b2 - (c <<< (2 * rsi_pkg::FRAC_BITS))) >= 0));
		dq = b2 - a * c;
		res.miss = dq < 0;
		hi = (wide_t'(1) <<< (rsi_pkg::COORD_WIDTH - 1)) - 1;
		lo = -(wide_t'(1) <<< (rsi_pkg::COORD_WIDTH - 1));
		if (res.miss || a == 0) begin
			q = -(wide_t'(1) <<< rsi_pkg::FRAC_BITS);
		end else begin
			sq_arg = dq <<< (2 * rsi_pkg::FRAC_BITS);
			root = 0;
			for (int bit_i = 110; bit_i >= 0; bit_i--) begin
				trial = root | (wide_t'(1) <<< bit_i);
				if (trial * trial <= sq_arg)
					root = trial;
			end
			num = -(b <<< rsi_pkg::FRAC_BITS) - root;
			q = num / a;
			rem = num % a;
			if (rem != 0 && num < 0)
				q = q - 1;
			if (q > hi)
				q = hi;
			if (q < lo)
				q = lo;
		end
		res.near_t = q[rsi_pkg::COORD_WIDTH-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		rsi_pkg::ray_res_t exp_r;
		if (arst_n && start && !busy) begin
			expected_hits.push_back(solve_sphere(req));
			sent++;
		end
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: result with nothing expected: hit=%0b miss=%0b t=%0h",
					$time, result.hit_ahead, result.miss, result.near_t);
				errors++;
			end else begin
				exp_r = expected_hits.pop_front();
				checked++;
				if (result.hit_ahead !== exp_r.hit_ahead) begin
					$display("%0t: hit_ahead expected %0b actual %0b", $time,
						exp_r.hit_ahead, result.hit_ahead);
					errors++;
				end
				if (result.miss !== exp_r.miss) begin
					$display("%0t: miss expected %0b actual %0b", $time,
						exp_r.miss, result.miss);
					errors++;
				end
				if (result.near_t !== exp_r.near_t) begin
					$display("%0t: near_t expected %0h actual %0h", $time,
						exp_r.near_t, result.near_t);
					errors++;
				end
			end
		end
	end

	// called at a rising edge; returns at the edge that accepted the request
	task automatic send_ray(rsi_pkg::ray_req_t r);
		// each idle cycle is drawn on its own, so idle cycles make up the given share
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req   <= r;
		start <= 1'b1;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
	endtask

	task automatic idle_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		return $urandom();
	endfunction

	function automatic rsi_pkg::ray_req_t make_ray(int ox, int oy, int oz, int dx, int dy,
		int dz, int cx, int cy, int cz, int rad);
		rsi_pkg::ray_req_t r;
		r.origin_x = ox;
		r.origin_y = oy;
		r.origin_z = oz;
		r.dir_x    = dx;
		r.dir_y    = dy;
		r.dir_z    = dz;
		r.center_x = cx;
		r.center_y = cy;
		r.center_z = cz;
		r.radius   = rad[rsi_pkg::COORD_WIDTH-2:0];
		return r;
	endfunction

	// raw bits everywhere
	function automatic rsi_pkg::ray_req_t noise_ray();
		rsi_pkg::ray_req_t r;
		logic [319:0]      raw;
		raw = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
		r = raw[$bits(rsi_pkg::ray_req_t)-1:0];
		return r;
	endfunction

	// scene-like: coordinates within +-64, direction components within +-1.0, modest radius
	function automatic rsi_pkg::ray_req_t scene_ray();
		rsi_pkg::ray_req_t r;
		int                span;
		span = 1 << ($urandom_range(8, 22));
		r.origin_x = $signed($urandom_range(0, 2 * span)) - span;
		r.origin_y = $signed($urandom_range(0, 2 * span)) - span;
		r.origin_z = $signed($urandom_range(0, 2 * span)) - span;
		r.center_x = $signed($urandom_range(0, 2 * span)) - span;
		r.center_y = $signed($urandom_range(0, 2 * span)) - span;
		r.center_z = $signed($urandom_range(0, 2 * span)) - span;
		r.dir_x    = $signed($urandom_range(0, 131072)) - 65536;
		r.dir_y    = $signed($urandom_range(0, 131072)) - 65536;
		r.dir_z    = $signed($urandom_range(0, 131072)) - 65536;
		r.radius   = 31'($urandom_range(0, span));
		return r;
	endfunction

	task automatic test_directed();
		int one;
		int mx;
		int mn;
		one = 1 << rsi_pkg::FRAC_BITS;
		mx  = 32'h7fffffff;
		mn  = 32'h80000000;
		// sphere straight ahead
		send_ray(make_ray(0, 0, 0, one, 0, 0, 5 * one, 0, 0, one));
		// sphere behind
		send_ray(make_ray(0, 0, 0, one, 0, 0, -5 * one, 0, 0, one));
		// clean miss
		send_ray(make_ray(0, 0, 0, one, 0, 0, 5 * one, 5 * one, 0, one));
		// tangent
		send_ray(make_ray(0, 0, 0, one, 0, 0, 5 * one, one, 0, one));
		// origin inside sphere
		send_ray(make_ray(0, 0, 0, 0, one, 0, 0, 0, 0, 2 * one));
		// zero direction, inside and outside
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, one));
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 9 * one, 0, 0, one));
		// all zero, radius zero
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// tiny direction, far sphere: root saturates high, then low
		send_ray(make_ray(0, 0, 0, 1, 0, 0, mx, 0, 0, 1));
		send_ray(make_ray(0, 0, 0, -1, 0, 0, mx, 0, 0, mx));
		// extremes of every field
		send_ray(make_ray(mx, mx, mx, mx, mx, mx, mn, mn, mn, mx));
		send_ray(make_ray(mn, mn, mn, mn, mn, mn, mx, mx, mx, mx));
		send_ray(make_ray(mn, mn, mn, mx, mx, mx, mx, mx, mx, 0));
		send_ray(make_ray(mx, mn, mx, mn, mx, mn, mn, mx, mn, mx));
		send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, mx));
		send_ray(make_ray(mn, 0, 0, mx, 0, 0, 0, 0, 0, 32'h40000000));
		send_ray(make_ray(0, 0, 0, mn, 0, 0, mn, 0, 0, mx));
		// negative root with non-unit direction
		send_ray(make_ray(0, 0, 0, 3 * one, -2 * one, one, -one, one, 0, 5 * one));
	endtask

	task automatic test_random(int count, int idle_pct);
		send_idle_pct = idle_pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75)
				send_ray(scene_ray());
			else
				send_ray(noise_ray());
		end
	endtask

	initial begin
		errors  = 0;
		sent    = 0;
		checked = 0;
		send_idle_pct = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_until_drained();
		test_random(170, 38);
		// full pipeline drain mid-run
		idle_until_drained();
		test_random(170, 58);
		test_random(170, 0);
		start <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		$display("%0d rays sent, %0d results checked: directed edge cases, scene-like and",
			sent, checked);
		$display("raw-bit rays under three sender gap patterns");
		if (errors == 0 && expected_hits.size() == 0) begin
			$display("tb_ray_sphere_intersect: PASS");
		end else begin
			$display("tb_ray_sphere_intersect: FAIL");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb_ray_sphere_intersect: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/rsi_isqrt.sv
rtl/ray_sphere_intersect.sv
tb/sv/tb_ray_sphere_intersect.sv
